FILE: src/zip_header_name_extractor_assert.svh
// ============================================================================
// Assertion macros for the ZIP header name extractor
// Shared property forms, clocked on the block clock and disabled in reset.
// ============================================================================
`ifndef ZIP_HEADER_NAME_EXTRACTOR_ASSERT_SVH
`define ZIP_HEADER_NAME_EXTRACTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZHNE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZHNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/zhne_pkg.sv
// ============================================================================
// ZIP header name extractor package
// Shared types and constants for the parser, the result queue and the top.
// ============================================================================
package zhne_pkg;

    // Signatures as seen in the four-byte window, oldest byte highest.
    localparam logic [31:0] LocalSig = 32'h504B_0304;
    localparam logic [31:0] EndSig   = 32'h504B_0506;

    // Header offsets of interest.
    localparam logic [4:0] OffLenLo  = 5'd26;
    localparam logic [4:0] OffLenHi  = 5'd27;
    localparam logic [4:0] OffLast   = 5'd29;
    localparam logic [4:0] OffBody   = 5'd4;
    localparam logic [4:0] SearchMin = 5'd3;

    // Result queue depth and the level at which input is still taken.
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QLvlW  = 3;
    localparam logic [QLvlW-1:0] QReadyMax = 3'd2;

    // Result kinds.
    localparam logic KindName    = 1'b0;
    localparam logic KindVerdict = 1'b1;

    // Verdict codes.
    typedef enum logic [1:0] {
        VERDICT_ORDINARY = 2'd0,
        VERDICT_ZIP      = 2'd1,
        VERDICT_EMPTY    = 2'd2
    } verdict_t;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_HEADER = 3'b010,
        PH_NAME   = 3'b100
    } phase_t;

    // One result item.
    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       name_end;
        verdict_t   verdict;
        logic       name_truncated;
    } result_t;

    // Results produced by one input transfer, packed from r0 up.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

FILE: src/zhne_parser.sv
// ============================================================================
// ZIP header name extractor parser
// Signature window, header offset counter and name counter; turns each
// accepted byte into zero, one or two result items in the cycle it is taken.
// ============================================================================
module zhne_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_take,
    input  logic [7:0]           in_byte,
    input  logic                 in_eof,
    output zhne_pkg::push_t      push
);

    logic [23:0]      recent_reg, recent_next;
    zhne_pkg::phase_t phase_reg, phase_next;
    logic [4:0]       offset_reg, offset_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      remain_reg, remain_next;
    logic             saw_local_reg, saw_local_next;
    logic             saw_end_reg, saw_end_next;

    logic [31:0]         window;
    logic                local_sig;
    logic                end_sig;
    logic                name_last;
    zhne_pkg::result_t   name_res;
    zhne_pkg::result_t   verdict_res;
    logic                have_name;

    // Signature compare over the last three bytes and the new one.
    assign window    = {recent_reg, in_byte};
    assign local_sig = (window == zhne_pkg::LocalSig);
    assign end_sig   = (window == zhne_pkg::EndSig);
    assign name_last = (remain_reg <= 16'd1);

    // Next-state logic for one byte.
    always_comb begin
        recent_next    = window[23:0];
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        len_next       = len_reg;
        remain_next    = remain_reg;
        saw_local_next = saw_local_reg | local_sig;
        saw_end_next   = saw_end_reg | end_sig;
        have_name      = 1'b0;

        case (phase_reg)
            zhne_pkg::PH_SEARCH: begin
                if (local_sig && offset_reg >= zhne_pkg::SearchMin) begin
                    phase_next  = zhne_pkg::PH_HEADER;
                    offset_next = zhne_pkg::OffBody;
                    len_next    = 16'd0;
                end else if (offset_reg < zhne_pkg::SearchMin) begin
                    offset_next = offset_reg + 5'd1;
                end
            end
            zhne_pkg::PH_HEADER: begin
                if (offset_reg == zhne_pkg::OffLenLo) begin
                    len_next = {len_reg[15:8], in_byte};
                end else if (offset_reg == zhne_pkg::OffLenHi) begin
                    len_next = {in_byte, len_reg[7:0]};
                end
                if (offset_reg >= zhne_pkg::OffLast) begin
                    if (len_reg == 16'd0) begin
                        phase_next  = zhne_pkg::PH_SEARCH;
                        offset_next = 5'd0;
                    end else begin
                        phase_next  = zhne_pkg::PH_NAME;
                        remain_next = len_reg;
                    end
                end else begin
                    offset_next = offset_reg + 5'd1;
                end
            end
            zhne_pkg::PH_NAME: begin
                have_name = 1'b1;
                if (name_last) begin
                    remain_next = 16'd0;
                    phase_next  = zhne_pkg::PH_SEARCH;
                    offset_next = 5'd0;
                end else begin
                    remain_next = remain_reg - 16'd1;
                end
            end
            default: begin
                phase_next  = zhne_pkg::PH_SEARCH;
                offset_next = 5'd0;
            end
        endcase

        // End of file: the block returns to its reset state.
        if (in_eof) begin
            recent_next    = 24'd0;
            phase_next     = zhne_pkg::PH_SEARCH;
            offset_next    = 5'd0;
            len_next       = 16'd0;
            remain_next    = 16'd0;
            saw_local_next = 1'b0;
            saw_end_next   = 1'b0;
        end
    end

    // Result items for this byte.
    always_comb begin
        name_res                = '0;
        name_res.kind           = zhne_pkg::KindName;
        name_res.name_byte      = in_byte;
        name_res.name_end       = name_last;
        name_res.verdict        = zhne_pkg::VERDICT_ORDINARY;

        verdict_res             = '0;
        verdict_res.kind        = zhne_pkg::KindVerdict;
        verdict_res.verdict     = (saw_local_reg | local_sig) ? zhne_pkg::VERDICT_ZIP :
                                  (saw_end_reg | end_sig)     ? zhne_pkg::VERDICT_EMPTY :
                                                                zhne_pkg::VERDICT_ORDINARY;
        // Phase after this byte, before the end-of-file clear.
        verdict_res.name_truncated = 1'b0;
        case (phase_reg)
            zhne_pkg::PH_SEARCH: begin
                verdict_res.name_truncated =
                    local_sig && (offset_reg >= zhne_pkg::SearchMin);
            end
            zhne_pkg::PH_HEADER: begin
                verdict_res.name_truncated =
                    !(offset_reg >= zhne_pkg::OffLast && len_reg == 16'd0);
            end
            zhne_pkg::PH_NAME: begin
                verdict_res.name_truncated = !name_last;
            end
            default: begin
                verdict_res.name_truncated = 1'b0;
            end
        endcase

        push = '0;
        if (in_take) begin
            if (have_name) begin
                push.r0  = name_res;
                push.r1  = verdict_res;
                push.cnt = in_eof ? 2'd2 : 2'd1;
            end else begin
                push.r0  = verdict_res;
                push.cnt = in_eof ? 2'd1 : 2'd0;
            end
        end
    end

    // State registers, updated on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg    <= 24'd0;
            phase_reg     <= zhne_pkg::PH_SEARCH;
            offset_reg    <= 5'd0;
            len_reg       <= 16'd0;
            remain_reg    <= 16'd0;
            saw_local_reg <= 1'b0;
            saw_end_reg   <= 1'b0;
        end else if (in_take) begin
            recent_reg    <= recent_next;
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            saw_local_reg <= saw_local_next;
            saw_end_reg   <= saw_end_next;
        end
    end

endmodule

FILE: src/zhne_result_fifo.sv
// ============================================================================
// ZIP header name extractor result queue
// Four-entry queue that takes up to two results per cycle and hands out one.
// ============================================================================
module zhne_result_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  zhne_pkg::push_t               push,
    input  logic                          pop,
    output zhne_pkg::result_t             head,
    output logic                          not_empty,
    output logic [zhne_pkg::QLvlW-1:0]    level
);

    zhne_pkg::result_t               mem [zhne_pkg::QDepth];
    logic [zhne_pkg::QPtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [zhne_pkg::QPtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [zhne_pkg::QLvlW-1:0]      level_reg, level_next;
    logic [zhne_pkg::QPtrW-1:0]      wr_ptr_plus1;
    logic                            do_pop;

    assign do_pop       = pop && (level_reg != '0);
    assign wr_ptr_plus1 = wr_ptr_reg + {{(zhne_pkg::QPtrW-1){1'b0}}, 1'b1};

    // Pointer and level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {{(zhne_pkg::QPtrW-1){1'b0}}, do_pop};
        level_next  = level_reg + {1'b0, push.cnt}
                      - {{(zhne_pkg::QLvlW-1){1'b0}}, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage: first result at the write pointer, second just after it.
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push.r1;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

FILE: src/zip_header_name_extractor.sv
// ============================================================================
// ZIP header name extractor
// Finds ZIP local headers in a byte stream and emits the stored file names.
// ============================================================================
// Usage:
//   The input stream carries one file byte per transfer in s_tdata, with
//   s_tlast on the final byte of the file. The output stream carries one
//   result per transfer: m_tuser 0 is a name byte (m_tlast on the last byte
//   of a name), m_tuser 1 is the end-of-file verdict with the truncated flag.
//   A byte is parsed in the cycle it is taken; its results are registered
//   in the result queue ahead of the output. One byte is taken each cycle
//   while s_tready is high; a byte that yields a name byte and a verdict
//   needs two transfers on the single output port of the four-entry queue.
//   s_tready is high while the queue holds at most two results, so a stalled
//   receiver fills the queue and then holds off the sender; nothing is lost.
//   Reset clears the parser state and empties the queue; the first byte
//   after reset or after a final byte starts a new file.
// ============================================================================
module zip_header_name_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] name_byte, [9:8] verdict,
                                   // [10] name_truncated, [15:11] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast
);

`include "zip_header_name_extractor_assert.svh"

    zhne_pkg::push_t                 push;
    zhne_pkg::result_t               head;
    logic                            not_empty;
    logic [zhne_pkg::QLvlW-1:0]      level;
    logic                            in_take;

    // Input is taken while the queue has room for two results.
    assign s_tready = (level <= zhne_pkg::QReadyMax);
    assign in_take  = s_tvalid && s_tready;

    zhne_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_byte (s_tdata),
        .in_eof  (s_tlast),
        .push    (push)
    );

    zhne_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tready),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    // Output packing.
    assign m_tvalid = not_empty;
    assign m_tdata  = {5'd0, head.name_truncated, head.verdict, head.name_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.name_end;

    // Checks.
    `ZHNE_ASSERT_IMPLIES(a_level_bound, aclk, aresetn, 1'b1,
        level <= 3'd4, "result queue level above its depth")
    `ZHNE_ASSERT_IMPLIES(a_pair_order, aclk, aresetn, push.cnt == 2'd2,
        push.r0.kind == zhne_pkg::KindName && push.r1.kind == zhne_pkg::KindVerdict,
        "two results from one byte must be a name byte then a verdict")
    `ZHNE_ASSERT_IMPLIES(a_verdict_clean, aclk, aresetn, m_tvalid && m_tuser,
        !m_tlast && m_tdata[7:0] == 8'd0, "verdict result carries name fields")
    `ZHNE_ASSERT_NEXT(a_hold_stable, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "output transfer changed while the receiver stalled")

endmodule

FILE: tb/zip_header_name_extractor_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ZIP header name extractor testbench
// Streams files one byte per transfer into the extractor and compares every
// name byte and end-of-file verdict with a cycle-free model of the parser;
// a short table of hand-made files, with its own verdicts, comes first.
// Random files follow: well-formed archives, empty archives, noise and
// broken signatures, with the sender and the receiver idling at random.
// ============================================================================
module zip_header_name_extractor_tb;

    localparam int PhaseBytes = 315;
    localparam int HoldCycles = 250;
    localparam int DrainCycles = 8;
    localparam int CycleLimit = 400000;
    localparam int MaxReports = 10;

    // One row of the directed table; rows with a typed expectation end a file.
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               typed;
        zhne_pkg::verdict_t verdict;
        logic               trunc;
    } file_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] name_byte, [9:8] verdict, [10] name_truncated
    logic        m_tuser;   // [0] kind
    logic        m_tlast;

    // Parser state as the model sees it.
    logic [23:0]       last_three;
    zhne_pkg::phase_t  parse_phase;
    logic [4:0]        hdr_pos;
    logic [15:0]       name_len;
    logic [15:0]       name_left;
    logic              seen_local;
    logic              seen_end;

    zhne_pkg::result_t due_results [$];
    logic [7:0]        file_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int phase_bytes = 0;
    int files_sent = 0;
    int name_bytes = 0;
    int names_done = 0;
    int zip_count = 0;
    int empty_count = 0;
    int plain_count = 0;
    int cut_count = 0;

    file_row_t directed_rows [21] = '{
        '{8'hFF, 1'b1, 1'b1, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h00, 1'b1, 1'b1, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        // Local signature at offset 0, file ends on its last byte.
        '{8'h50, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h4B, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h03, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h04, 1'b1, 1'b1, zhne_pkg::VERDICT_ZIP, 1'b1},
        // End record only.
        '{8'h50, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h4B, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h05, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h06, 1'b1, 1'b1, zhne_pkg::VERDICT_EMPTY, 1'b0},
        // Three-byte file never matches.
        '{8'h50, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h4B, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h03, 1'b1, 1'b1, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        // End record then a local header: zip wins.
        '{8'h50, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h4B, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h05, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h06, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h50, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h4B, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h03, 1'b0, 1'b0, zhne_pkg::VERDICT_ORDINARY, 1'b0},
        '{8'h04, 1'b1, 1'b1, zhne_pkg::VERDICT_ZIP, 1'b1}
    };

    zip_header_name_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("zip_header_name_extractor_tb failed");
            $finish;
        end
    end

    task automatic clear_parser();
        last_three = '0;
        parse_phase = zhne_pkg::PH_SEARCH;
        hdr_pos = '0;
        name_len = '0;
        name_left = '0;
        seen_local = 1'b0;
        seen_end = 1'b0;
    endtask

    // Advance the parser by one file byte; queue the results when asked.
    task automatic parse_byte(input logic [7:0] b, input logic eof, input logic keep);
        logic [31:0]        window;
        logic               is_local;
        logic               is_end;
        logic               final_name;
        zhne_pkg::verdict_t vd;
        zhne_pkg::result_t  r;
        window = {last_three, b};
        is_local = (window == zhne_pkg::LocalSig);
        is_end = (window == zhne_pkg::EndSig);
        if (is_local) seen_local = 1'b1;
        if (is_end) seen_end = 1'b1;

        case (parse_phase)
            zhne_pkg::PH_SEARCH: begin
                if (is_local && hdr_pos >= zhne_pkg::SearchMin) begin
                    parse_phase = zhne_pkg::PH_HEADER;
                    hdr_pos = zhne_pkg::OffBody;
                    name_len = '0;
                end else if (hdr_pos < zhne_pkg::SearchMin) begin
                    hdr_pos = hdr_pos + 5'd1;
                end
            end
            zhne_pkg::PH_HEADER: begin
                if (hdr_pos == zhne_pkg::OffLenLo) name_len[7:0] = b;
                else if (hdr_pos == zhne_pkg::OffLenHi) name_len[15:8] = b;
                if (hdr_pos >= zhne_pkg::OffLast) begin
                    if (name_len == 16'd0) begin
                        parse_phase = zhne_pkg::PH_SEARCH;
                        hdr_pos = '0;
                    end else begin
                        parse_phase = zhne_pkg::PH_NAME;
                        name_left = name_len;
                    end
                end else begin
                    hdr_pos = hdr_pos + 5'd1;
                end
            end
            default: begin
                final_name = (name_left <= 16'd1);
                r = '{zhne_pkg::KindName, b, final_name, zhne_pkg::VERDICT_ORDINARY, 1'b0};
                if (keep) due_results.push_back(r);
                if (final_name) begin
                    name_left = '0;
                    parse_phase = zhne_pkg::PH_SEARCH;
                    hdr_pos = '0;
                end else begin
                    name_left = name_left - 16'd1;
                end
            end
        endcase

        last_three = window[23:0];

        // Verdict closes the file and restarts the parser.
        if (eof) begin
            if (seen_local) vd = zhne_pkg::VERDICT_ZIP;
            else if (seen_end) vd = zhne_pkg::VERDICT_EMPTY;
            else vd = zhne_pkg::VERDICT_ORDINARY;
            r = '{zhne_pkg::KindVerdict, 8'h00, 1'b0, vd,
                  parse_phase != zhne_pkg::PH_SEARCH};
            if (keep) due_results.push_back(r);
            clear_parser();
        end
    endtask

    // Offer one byte, idling first at the current rate, and predict on transfer.
    task automatic send_byte(input logic [7:0] b, input logic eof, input logic keep);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_byte(b, eof, keep);
        bytes_sent++;
        phase_bytes++;
    endtask

    // Random byte, often one of the signature values or an extreme.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(7))
                0: return 8'h00;
                1: return 8'hFF;
                2: return zhne_pkg::LocalSig[31:24];
                3: return zhne_pkg::LocalSig[23:16];
                4: return zhne_pkg::LocalSig[15:8];
                5: return zhne_pkg::LocalSig[7:0];
                6: return zhne_pkg::EndSig[15:8];
                default: return zhne_pkg::EndSig[7:0];
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(199);
        if (r < 40) return 16'd0;
        if (r < 176) return 16'($urandom_range(1, 12));
        if (r < 198) return 16'($urandom_range(13, 40));
        return 16'($urandom_range(256, 259));
    endfunction

    task automatic add_junk(input int n);
        repeat (n) file_q.push_back(pick_byte());
    endtask

    task automatic add_sig(input logic [31:0] s);
        file_q.push_back(s[31:24]);
        file_q.push_back(s[23:16]);
        file_q.push_back(s[15:8]);
        file_q.push_back(s[7:0]);
    endtask

    // Local header with the given length field, followed by emit_n name bytes.
    task automatic add_entry(input logic [15:0] len, input int emit_n);
        int at;
        add_sig(zhne_pkg::LocalSig);
        add_junk(22);
        file_q.push_back(len[7:0]);
        file_q.push_back(len[15:8]);
        add_junk(2 + emit_n);
        // Now and then a signature hides inside the name.
        if (emit_n >= 4 && $urandom_range(5) == 0) begin
            at = file_q.size() - emit_n + $urandom_range(emit_n - 4);
            for (int i = 0; i < 4; i++) begin
                file_q[at + i] = $urandom_range(1) ? zhne_pkg::LocalSig[31 - 8*i -: 8]
                                                   : zhne_pkg::EndSig[31 - 8*i -: 8];
            end
        end
    endtask

    // Build one random file and stream it; long_name forces an archive whose
    // name fills the result queue while the receiver holds off.
    task automatic send_file(input logic long_name);
        int kind_pick;
        int entries;
        int cut;
        int len;
        kind_pick = long_name ? 0 : $urandom_range(99);
        file_q.delete();

        if (long_name) begin
            add_entry(16'd40, 40);
        end else if (kind_pick < 55) begin
            // Archive: some entries, the last one possibly cut short.
            if ($urandom_range(2) != 0) add_junk($urandom_range(1, 4));
            entries = $urandom_range(1, 3);
            cut = 9;
            for (int e = 0; e < entries; e++) begin
                if (e == entries - 1) cut = $urandom_range(6);
                if (cut == 0) begin
                    add_entry(pick_len(), 0);
                    repeat ($urandom_range(1, 26)) void'(file_q.pop_back());
                end else if (cut == 1) begin
                    len = $urandom_range(2, 65535);
                    add_entry(16'(len), $urandom_range(1, (len - 1 < 12) ? len - 1 : 12));
                end else begin
                    len = pick_len();
                    add_entry(16'(len), len);
                    if (e != entries - 1 && $urandom_range(2) == 0)
                        add_junk($urandom_range(1, 3));
                end
            end
            if (cut > 1) begin
                case ($urandom_range(3))
                    0: begin
                        add_sig(zhne_pkg::EndSig);
                        add_junk($urandom_range(18));
                    end
                    1: add_junk($urandom_range(1, 6));
                    default: ;
                endcase
            end
        end else if (kind_pick < 70) begin
            // Empty archive: only an end record.
            add_junk($urandom_range(1) ? 0 : $urandom_range(1, 6));
            add_sig(zhne_pkg::EndSig);
            add_junk($urandom_range(18));
        end else if (kind_pick < 85) begin
            add_junk($urandom_range(1, 24));
        end else begin
            // Broken signatures: partial, bit-flipped or glued together.
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(3))
                    0: begin
                        len = $urandom_range(1, 3);
                        for (int i = 0; i < len; i++)
                            file_q.push_back(zhne_pkg::LocalSig[31 - 8*i -: 8]);
                    end
                    1: add_sig(zhne_pkg::LocalSig ^ (32'h1 << $urandom_range(31)));
                    2: add_sig(zhne_pkg::EndSig ^ (32'h1 << $urandom_range(31)));
                    default: file_q.push_back(pick_byte());
                endcase
            end
        end
        if (file_q.size() == 0) file_q.push_back(pick_byte());

        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, 1'b1);
        files_sent++;
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HoldCycles;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input zhne_pkg::result_t want,
                                   input zhne_pkg::result_t got);
        mismatches++;
        if (mismatches <= MaxReports) begin
            $display("%s at cycle %0d: expected kind %0d byte %02h end %0d verdict %0d trunc %0d,",
                     what, cycle_count, want.kind, want.name_byte, want.name_end,
                     want.verdict, want.name_truncated);
            $display("    got kind %0d byte %02h end %0d verdict %0d trunc %0d",
                     got.kind, got.name_byte, got.name_end, got.verdict, got.name_truncated);
        end
    endtask

    // Result checker: each output transfer against the oldest expectation.
    always @(posedge aclk) begin
        zhne_pkg::result_t got;
        zhne_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.name_byte = m_tdata[7:0];
            got.name_end = m_tlast;
            got.verdict = zhne_pkg::verdict_t'(m_tdata[9:8]);
            got.name_truncated = m_tdata[10];
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.name_byte !== want.name_byte
                        || got.name_end !== want.name_end || got.verdict !== want.verdict
                        || got.name_truncated !== want.name_truncated)
                    report_mismatch("result mismatch", want, got);
                if (want.kind == zhne_pkg::KindVerdict) begin
                    case (want.verdict)
                        zhne_pkg::VERDICT_ZIP: zip_count++;
                        zhne_pkg::VERDICT_EMPTY: empty_count++;
                        default: plain_count++;
                    endcase
                    if (want.name_truncated) cut_count++;
                end else begin
                    name_bytes++;
                    if (want.name_end) names_done++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int idle_send [4] = '{0, 70, 0, 13};
        int idle_recv [4] = '{0, 0, 70, 13};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed files from the table.
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].last, !directed_rows[i].typed);
            if (directed_rows[i].typed)
                due_results.push_back('{zhne_pkg::KindVerdict, 8'h00, 1'b0,
                                        directed_rows[i].verdict, directed_rows[i].trunc});
        end
        files_sent += 6;

        // Random files, one idling pattern per phase.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_send[p];
            recv_stall_pct = idle_recv[p];
            phase_bytes = 0;
            if (p == 0) begin
                hold_requests++;
                send_file(1'b1);
            end
            while (phase_bytes < PhaseBytes) send_file(1'b0);
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("covered %0d files in %0d byte transfers: %0d zip, %0d empty zip, %0d plain",
                 files_sent, bytes_sent, zip_count, empty_count, plain_count);
        $display("%0d files ended inside a header or name; %0d name bytes in %0d full names",
                 cut_count, name_bytes, names_done);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("zip_header_name_extractor_tb passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     due_results.size());
            $display("zip_header_name_extractor_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/zhne_pkg.sv
src/zhne_parser.sv
src/zhne_result_fifo.sv
src/zip_header_name_extractor.sv
tb/zip_header_name_extractor_tb.sv
